/* hw/rtl/block_buffer_cache_assert.svh */
// Assertion macros used by the checker of the buffer cache.
// Plain text only; no dependencies.
`ifndef BLOCK_BUFFER_CACHE_ASSERT_SVH
`define BLOCK_BUFFER_CACHE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("buffer cache assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define BBC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("buffer cache assertion failed");

`endif

/* hw/rtl/bbc_pkg.sv */
// Shared constants and types of the buffer cache.
// No dependencies; used by the top level, the checker and the testbench.
package bbc_pkg;

  localparam int unsigned DefBufferCount = 8;
  localparam int unsigned BlockBits      = 24;
  localparam int unsigned IndexBits      = 3;
  localparam int unsigned StatusBits     = 3;

  typedef enum logic [StatusBits-1:0] {
    StHit      = 3'd0,
    StMiss     = 3'd1,
    StBusy     = 3'd2,
    StNoFree   = 3'd3,
    StReleased = 3'd4,
    StNotBusy  = 3'd5
  } status_e;

  typedef enum logic {
    ModeRead    = 1'b0,
    ModeRelease = 1'b1
  } mode_e;

endpackage

/* hw/rtl/bbc_tag_ram.sv */
// Tag store of the buffer cache: one write port, one registered read port.
// Depends on nothing but its parameters.
module bbc_tag_ram #(
  parameter int unsigned Depth = 8,
  parameter int unsigned Width = 24
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hw/rtl/block_buffer_cache.sv */
// Buffer cache top level: tag search, free-list order and result register.
// Depends on bbc_pkg and bbc_tag_ram.
//
//  Channel | Handshake                  | Payload
//  --------+----------------------------+----------------------------
//  in      | in_valid_i / in_stall_o    | mode_i, block_number_i
//  out     | out_valid_o / out_stall_i  | status_o, buffer_index_o
//
// The sequencer walks the tag RAM one slot per cycle through its single read
// port, then commits. Input stall is high from acceptance until commit.
// The commit waits while the result register still holds an unaccepted item.
// Reset empties every buffer and orders the free list by slot number.
module block_buffer_cache #(
  parameter int unsigned BUFFER_COUNT = bbc_pkg::DefBufferCount
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           mode_i,
  input  logic [bbc_pkg::BlockBits-1:0]  block_number_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [bbc_pkg::StatusBits-1:0] status_o,
  output logic [bbc_pkg::IndexBits-1:0]  buffer_index_o
);

  localparam int unsigned SlotW = $clog2(BUFFER_COUNT);
  localparam int unsigned ExtW  = SlotW + bbc_pkg::IndexBits;

  typedef enum logic [1:0] {
    SIdle,
    SSearch,
    SCommit
  } state_e;

  state_e                          state_q;
  logic [SlotW-1:0]                cnt_q;
  logic                            hit_found_q, hit_locked_q, hit_valid_q;
  logic [SlotW-1:0]                hit_slot_q, hit_rank_q;
  logic                            cand_found_q;
  logic [SlotW-1:0]                cand_slot_q, cand_rank_q;
  logic [BUFFER_COUNT-1:0]         present_q, locked_q, valid_q;
  logic [SlotW-1:0]                rank_q [BUFFER_COUNT];
  logic                            out_valid_q;
  bbc_pkg::status_e                status_q;
  logic [bbc_pkg::IndexBits-1:0]   index_q;

  // Item payload, captured at acceptance.
  bbc_pkg::mode_e                  mode_q;
  logic [bbc_pkg::BlockBits-1:0]   blk_q;

  logic [SlotW-1:0]                raddr;
  logic [bbc_pkg::BlockBits-1:0]   tag_rdata;
  logic                            in_accept, last_slot, tag_match, better_cand;
  logic                            commit_go;
  logic                            do_lock, do_fill, do_release, keep_idx;
  bbc_pkg::status_e                res_status;
  logic [SlotW-1:0]                act_slot;
  logic [ExtW-1:0]                 act_slot_ext;

  assign in_stall_o = (state_q != SIdle);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign last_slot  = (cnt_q == SlotW'(BUFFER_COUNT - 1));

  // The RAM output is registered, so prefetch the next slot.
  assign raddr = (state_q == SIdle) ? '0 : SlotW'(cnt_q + 1'b1);

  bbc_tag_ram #(
    .Depth (BUFFER_COUNT),
    .Width (bbc_pkg::BlockBits)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (commit_go && do_fill),
    .waddr_i (act_slot),
    .wdata_i (blk_q),
    .raddr_i (raddr),
    .rdata_o (tag_rdata)
  );

  // A never-tagged buffer matches nothing, so the RAM's content is ignored
  // until its present bit is set.
  assign tag_match   = present_q[cnt_q] && (tag_rdata == blk_q);
  assign better_cand = !locked_q[cnt_q] &&
                       (!cand_found_q || (rank_q[cnt_q] < cand_rank_q));

  assign commit_go = (state_q == SCommit) && (!out_valid_q || !out_stall_i);

  always_comb begin
    res_status = bbc_pkg::StNotBusy;
    do_lock    = 1'b0;
    do_fill    = 1'b0;
    do_release = 1'b0;
    keep_idx   = 1'b0;
    if (mode_q == bbc_pkg::ModeRead) begin
      if (hit_found_q) begin
        if (hit_locked_q) begin
          res_status = bbc_pkg::StBusy;
        end else begin
          res_status = hit_valid_q ? bbc_pkg::StHit : bbc_pkg::StMiss;
          do_lock    = 1'b1;
          keep_idx   = 1'b1;
        end
      end else if (!cand_found_q) begin
        res_status = bbc_pkg::StNoFree;
      end else begin
        res_status = bbc_pkg::StMiss;
        do_lock    = 1'b1;
        do_fill    = 1'b1;
        keep_idx   = 1'b1;
      end
    end else if (hit_found_q && hit_locked_q) begin
      res_status = bbc_pkg::StReleased;
      do_release = 1'b1;
      keep_idx   = 1'b1;
    end
  end

  assign act_slot     = hit_found_q ? hit_slot_q : cand_slot_q;
  assign act_slot_ext = ExtW'(act_slot);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SIdle;
      cnt_q        <= '0;
      hit_found_q  <= 1'b0;
      hit_locked_q <= 1'b0;
      hit_valid_q  <= 1'b0;
      hit_slot_q   <= '0;
      hit_rank_q   <= '0;
      cand_found_q <= 1'b0;
      cand_slot_q  <= '0;
      cand_rank_q  <= '0;
      present_q    <= '0;
      locked_q     <= '0;
      valid_q      <= '0;
      for (int i = 0; i < BUFFER_COUNT; i++) begin
        rank_q[i] <= SlotW'(i);
      end
      out_valid_q  <= 1'b0;
      status_q     <= bbc_pkg::StHit;
      index_q      <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && !commit_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        SIdle: begin
          if (in_accept) begin
            state_q      <= SSearch;
            cnt_q        <= '0;
            hit_found_q  <= 1'b0;
            cand_found_q <= 1'b0;
          end
        end
        SSearch: begin
          if (tag_match && !hit_found_q) begin
            hit_found_q  <= 1'b1;
            hit_slot_q   <= cnt_q;
            hit_rank_q   <= rank_q[cnt_q];
            hit_locked_q <= locked_q[cnt_q];
            hit_valid_q  <= valid_q[cnt_q];
          end
          // The free buffer released longest ago carries the lowest rank.
          if (better_cand) begin
            cand_found_q <= 1'b1;
            cand_slot_q  <= cnt_q;
            cand_rank_q  <= rank_q[cnt_q];
          end
          if (last_slot) begin
            state_q <= SCommit;
          end else begin
            cnt_q <= SlotW'(cnt_q + 1'b1);
          end
        end
        SCommit: begin
          if (commit_go) begin
            state_q     <= SIdle;
            out_valid_q <= 1'b1;
            status_q    <= res_status;
            index_q     <= keep_idx ? act_slot_ext[bbc_pkg::IndexBits-1:0] : '0;
            if (do_lock) begin
              locked_q[act_slot] <= 1'b1;
              valid_q[act_slot]  <= 1'b1;
            end
            if (do_fill) begin
              present_q[act_slot] <= 1'b1;
            end
            if (do_release) begin
              locked_q[hit_slot_q] <= 1'b0;
              // Move the released buffer to the young end of the order.
              for (int j = 0; j < BUFFER_COUNT; j++) begin
                if (SlotW'(j) == hit_slot_q) begin
                  rank_q[j] <= SlotW'(BUFFER_COUNT - 1);
                end else if (rank_q[j] > hit_rank_q) begin
                  rank_q[j] <= SlotW'(rank_q[j] - 1'b1);
                end
              end
            end
          end
        end
        default: begin
          state_q <= SIdle;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mode_q <= bbc_pkg::mode_e'(mode_i);
      blk_q  <= block_number_i;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign buffer_index_o = index_q;

endmodule

/* hw/rtl/bbc_checker.sv */
// Port-level checker of the buffer cache, bound to the top level below.
// Depends on bbc_pkg and block_buffer_cache_assert.svh.
`include "block_buffer_cache_assert.svh"

module bbc_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           mode_i,
  input logic [bbc_pkg::BlockBits-1:0]  block_number_i,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [bbc_pkg::StatusBits-1:0] status_o,
  input logic [bbc_pkg::IndexBits-1:0]  buffer_index_o
);

  logic                                              in_accept;
  logic                                              out_held;
  logic                                              no_slot_status;
  logic [bbc_pkg::StatusBits+bbc_pkg::IndexBits-1:0] out_payload;

  assign in_accept      = in_valid_i && !in_stall_o;
  assign out_held       = out_valid_o && out_stall_i;
  assign out_payload    = {status_o, buffer_index_o};
  assign no_slot_status = out_valid_o &&
                          (status_o == bbc_pkg::StBusy ||
                           status_o == bbc_pkg::StNoFree ||
                           status_o == bbc_pkg::StNotBusy);

  // A stalled result item holds its payload.
  `BBC_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable(out_payload))

  // Results that use no buffer report slot zero.
  `BBC_ASSERT_IMPL(a_zero_index, clk_i, rst_ni, no_slot_status, buffer_index_o == '0)

  // Only one item is in work at a time.
  `BBC_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_accept, in_stall_o)

endmodule

bind block_buffer_cache bbc_checker u_bbc_checker (.*);

/* verif/block_buffer_cache_tb.sv */
// Self-checking testbench for block_buffer_cache: read and release requests
// are checked against a predictor of tag lookup, locking and LRU free-list order.
// Depends on bbc_pkg and the block_buffer_cache RTL.
module block_buffer_cache_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SlotCount     = bbc_pkg::DefBufferCount;
  localparam int unsigned BlkW          = bbc_pkg::BlockBits;
  localparam int unsigned IdxW          = bbc_pkg::IndexBits;
  localparam logic [3:0]  NoLink        = 4'(SlotCount);
  localparam int unsigned PoolSize      = 12;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned SettleCycles  = 4 * (SlotCount + 2);

  typedef struct packed {
    bbc_pkg::status_e status;
    logic [IdxW-1:0]  slot;
  } reply_t;

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           in_valid_i;
  logic                           in_stall_o;
  logic                           mode_i;
  logic [BlkW-1:0]                block_number_i;
  logic                           out_valid_o;
  logic                           out_stall_i;
  logic [bbc_pkg::StatusBits-1:0] status_o;
  logic [IdxW-1:0]                buffer_index_o;

  // Predicted cache state.
  logic [BlkW-1:0] slot_tag    [SlotCount];
  bit              slot_tagged [SlotCount];
  bit              slot_locked [SlotCount];
  bit              slot_filled [SlotCount];
  logic [3:0]      lru_prev    [SlotCount];
  logic [3:0]      lru_next    [SlotCount];
  logic [3:0]      lru_head;
  logic [3:0]      lru_tail;

  reply_t          pending_replies[$];
  logic [BlkW-1:0] block_pool [PoolSize];
  int unsigned     tx_idle_pct;
  int unsigned     rx_idle_pct;
  bit              hold_off_req;
  int unsigned     error_count;
  int unsigned     requests_sent;
  int unsigned     status_seen [6];

  block_buffer_cache u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .mode_i         (mode_i),
    .block_number_i (block_number_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .buffer_index_o (buffer_index_o)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  initial begin
    #5ms;
    $display("TB_ERROR");
    $finish;
  end

  function automatic void clear_cache_state();
    for (int i = 0; i < SlotCount; i++) begin
      slot_tag[i]    = '0;
      slot_tagged[i] = 1'b0;
      slot_locked[i] = 1'b0;
      slot_filled[i] = 1'b0;
      lru_prev[i]    = (i == 0) ? NoLink : 4'(i - 1);
      lru_next[i]    = (i + 1 < SlotCount) ? 4'(i + 1) : NoLink;
    end
    lru_head = '0;
    lru_tail = 4'(SlotCount - 1);
  endfunction

  function automatic logic [3:0] locate_block(logic [BlkW-1:0] blk);
    for (int i = 0; i < SlotCount; i++) begin
      if (slot_tagged[i] && slot_tag[i] == blk) return 4'(i);
    end
    return NoLink;
  endfunction

  function automatic void take_off_lru(logic [3:0] s);
    logic [3:0] p;
    logic [3:0] n;
    p = lru_prev[s];
    n = lru_next[s];
    if (p != NoLink) lru_next[p] = n;
    else lru_head = n;
    if (n != NoLink) lru_prev[n] = p;
    else lru_tail = p;
    lru_prev[s] = NoLink;
    lru_next[s] = NoLink;
  endfunction

  function automatic void put_on_lru(logic [3:0] s);
    lru_next[s] = NoLink;
    lru_prev[s] = lru_tail;
    if (lru_tail != NoLink) lru_next[lru_tail] = s;
    else lru_head = s;
    lru_tail = s;
  endfunction

  // Applies one request to the predicted state and returns its reply.
  function automatic reply_t resolve_request(bbc_pkg::mode_e mode,
                                             logic [BlkW-1:0] blk);
    reply_t     r;
    logic [3:0] s;
    s      = locate_block(blk);
    r.slot = '0;
    if (mode == bbc_pkg::ModeRead) begin
      if (s != NoLink) begin
        if (slot_locked[s]) begin
          r.status = bbc_pkg::StBusy;
        end else begin
          take_off_lru(s);
          slot_locked[s] = 1'b1;
          r.status       = slot_filled[s] ? bbc_pkg::StHit : bbc_pkg::StMiss;
          slot_filled[s] = 1'b1;
          r.slot         = s[IdxW-1:0];
        end
      end else if (lru_head == NoLink) begin
        r.status = bbc_pkg::StNoFree;
      end else begin
        s = lru_head;
        take_off_lru(s);
        slot_tag[s]    = blk;
        slot_tagged[s] = 1'b1;
        slot_locked[s] = 1'b1;
        slot_filled[s] = 1'b1;
        r.status       = bbc_pkg::StMiss;
        r.slot         = s[IdxW-1:0];
      end
    end else begin
      if (s != NoLink && slot_locked[s]) begin
        slot_locked[s] = 1'b0;
        put_on_lru(s);
        r.status = bbc_pkg::StReleased;
        r.slot   = s[IdxW-1:0];
      end else begin
        r.status = bbc_pkg::StNotBusy;
      end
    end
    return r;
  endfunction

  // Offers one item, waits for its acceptance and records the predicted reply.
  task automatic send_request(bbc_pkg::mode_e mode, logic [BlkW-1:0] blk);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    mode_i         <= mode;
    block_number_i <= blk;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_replies.push_back(resolve_request(mode, blk));
    requests_sent++;
  endtask

  task automatic wait_for_replies();
    in_valid_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stall, or a long hold-off when one is requested.
  initial begin
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end
      out_stall_i <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_replies
    reply_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_o < 6) status_seen[status_o]++;
      if (pending_replies.size() == 0) begin
        $display("%t: unexpected item: expected none, got status %0d slot %0d",
                 $time, status_o, buffer_index_o);
        error_count++;
      end else begin
        want = pending_replies.pop_front();
        if (status_o !== want.status) begin
          $display("%t: status mismatch: expected %0d, got %0d",
                   $time, want.status, status_o);
          error_count++;
        end
        if (buffer_index_o !== want.slot) begin
          $display("%t: buffer_index mismatch: expected %0d, got %0d",
                   $time, want.slot, buffer_index_o);
          error_count++;
        end
      end
    end
  end

  // Block 0 on an empty cache, the all-ones block, busy, not-busy, hits,
  // and exhausting every buffer until no free one is left.
  task automatic test_directed();
    send_request(bbc_pkg::ModeRead, 24'h000000);
    send_request(bbc_pkg::ModeRead, 24'hFFFFFF);
    send_request(bbc_pkg::ModeRead, 24'hFFFFFF);
    send_request(bbc_pkg::ModeRelease, 24'h000000);
    send_request(bbc_pkg::ModeRelease, 24'h000000);
    send_request(bbc_pkg::ModeRelease, 24'h123456);
    send_request(bbc_pkg::ModeRead, 24'h000000);
    send_request(bbc_pkg::ModeRelease, 24'hFFFFFF);
    send_request(bbc_pkg::ModeRead, 24'hAAAAAA);
    send_request(bbc_pkg::ModeRead, 24'h555555);
    send_request(bbc_pkg::ModeRead, 24'h800000);
    send_request(bbc_pkg::ModeRead, 24'h000001);
    send_request(bbc_pkg::ModeRead, 24'h7FFFFF);
    send_request(bbc_pkg::ModeRead, 24'h0F0F0F);
    send_request(bbc_pkg::ModeRead, 24'hF0F0F0);
    send_request(bbc_pkg::ModeRead, 24'hC33C5A);
    send_request(bbc_pkg::ModeRead, 24'h000000);
    send_request(bbc_pkg::ModeRelease, 24'hAAAAAA);
    send_request(bbc_pkg::ModeRelease, 24'h555555);
    send_request(bbc_pkg::ModeRead, 24'hFFFFFF);
    send_request(bbc_pkg::ModeRead, 24'hAAAAAA);
    send_request(bbc_pkg::ModeRead, 24'h555555);
  endtask

  // Mostly reads and releases over a small block pool so that hits, busy
  // buffers and evictions keep occurring; the rest is unrelated noise.
  task automatic test_random_traffic(int unsigned count, int unsigned tx_pct,
                                     int unsigned rx_pct);
    int unsigned     pick;
    int unsigned     held[$];
    logic [BlkW-1:0] blk;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < PoolSize; i++) block_pool[i] = BlkW'($urandom());
    repeat (count) begin
      pick = $urandom_range(99);
      held.delete();
      for (int i = 0; i < SlotCount; i++) begin
        if (slot_tagged[i] && slot_locked[i]) held.push_back(i);
      end
      blk = block_pool[$urandom_range(PoolSize - 1)];
      if (pick < 40) begin
        send_request(bbc_pkg::ModeRead, blk);
      end else if (pick < 75) begin
        if (held.size() != 0) begin
          send_request(bbc_pkg::ModeRelease,
                       slot_tag[held[$urandom_range(held.size() - 1)]]);
        end else begin
          send_request(bbc_pkg::ModeRead, blk);
        end
      end else if (pick < 88) begin
        send_request(bbc_pkg::ModeRelease, blk);
      end else begin
        send_request(bbc_pkg::mode_e'($urandom_range(1)), BlkW'($urandom()));
      end
    end
  endtask

  // The receiver holds off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    tx_idle_pct  = 0;
    hold_off_req = 1'b1;
    for (int i = 0; i < 8; i++) begin
      send_request(bbc_pkg::mode_e'(i % 2), block_pool[i % PoolSize]);
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    mode_i         = bbc_pkg::ModeRead;
    block_number_i = '0;
    tx_idle_pct    = 0;
    rx_idle_pct    = 0;
    hold_off_req   = 1'b0;
    error_count    = 0;
    requests_sent  = 0;
    foreach (status_seen[i]) status_seen[i] = 0;
    clear_cache_state();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    wait_for_replies();
    test_random_traffic(280, 12, 78);
    test_backpressure();
    test_random_traffic(280, 78, 12);
    wait_for_replies();
    test_random_traffic(290, 0, 0);
    wait_for_replies();
    repeat (SettleCycles) @(posedge clk_i);

    $display("Sent %0d requests with sender and receiver idling, a long hold-off",
             requests_sent);
    $display("and a drain; replies: hit %0d miss %0d busy %0d nofree %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
    $display("released %0d notbusy %0d", status_seen[4], status_seen[5]);
    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
